// File: rtl/ir_integer_alu_with_carry_unit_assert.svh
// ---------------------------------------------------------------------------
// Integer ALU assertion macros
// Shared concurrent assertion forms for the integer ALU modules.
// ---------------------------------------------------------------------------
`ifndef IR_INTEGER_ALU_WITH_CARRY_UNIT_ASSERT_SVH
`define IR_INTEGER_ALU_WITH_CARRY_UNIT_ASSERT_SVH

// Checked at every clock edge outside reset.
`define IRALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IRALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/iralu_pkg.sv
// ---------------------------------------------------------------------------
// Integer ALU package
// Operation codes, serial unit codes and shared helper functions.
// ---------------------------------------------------------------------------
package iralu_pkg;

  localparam int DATA_WIDTH_DEFAULT = 64;

  // Operation codes of the kind field.
  localparam logic [4:0] KIND_ADD      = 5'd0;
  localparam logic [4:0] KIND_SUB      = 5'd1;
  localparam logic [4:0] KIND_ADC      = 5'd2;
  localparam logic [4:0] KIND_SBB      = 5'd3;
  localparam logic [4:0] KIND_MUL      = 5'd4;
  localparam logic [4:0] KIND_DIV      = 5'd5;
  localparam logic [4:0] KIND_AND      = 5'd6;
  localparam logic [4:0] KIND_OR       = 5'd7;
  localparam logic [4:0] KIND_XOR      = 5'd8;
  localparam logic [4:0] KIND_ANDNOT   = 5'd9;
  localparam logic [4:0] KIND_NEG      = 5'd10;
  localparam logic [4:0] KIND_LSL      = 5'd11;
  localparam logic [4:0] KIND_LSR      = 5'd12;
  localparam logic [4:0] KIND_ASR      = 5'd13;
  localparam logic [4:0] KIND_ROR      = 5'd14;
  localparam logic [4:0] KIND_BSWAP    = 5'd15;
  localparam logic [4:0] KIND_EXTRACT  = 5'd16;
  localparam logic [4:0] KIND_INSERT   = 5'd17;
  localparam logic [4:0] KIND_CLEAR    = 5'd18;
  localparam logic [4:0] KIND_MULHIGH  = 5'd19;
  localparam logic [4:0] KIND_SEXT     = 5'd20;
  localparam logic [4:0] KIND_PARITY   = 5'd21;
  localparam logic [4:0] KIND_SETCARRY = 5'd22;
  localparam logic [4:0] KIND_INVCARRY = 5'd23;
  localparam logic [4:0] KIND_TESTBIT  = 5'd24;

  // Serial unit operations.
  localparam logic [1:0] MD_MUL  = 2'd0;
  localparam logic [1:0] MD_MULH = 2'd1;
  localparam logic [1:0] MD_DIV  = 2'd2;

  // Request handed to the serial multiply and divide unit.
  typedef struct packed {
    logic [1:0] op;
    logic       is_signed;
  } md_req_t;

  // All ones below bit n; saturates at 64 bits.
  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] r;
    if (n >= 7'd64) begin
      r = '1;
    end else begin
      r = (64'd1 << n[5:0]) - 64'd1;
    end
    return r;
  endfunction

  // Sign extend from the given width to 64 bits.
  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [6:0] bits);
    logic [63:0] m;
    logic [63:0] r;
    m = low_mask(bits);
    r = v & m;
    if (bits < 7'd64 && bits != 7'd0) begin
      if (r[6'(bits - 7'd1)]) begin
        r = r | ~m;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/iralu_logic.sv
// ---------------------------------------------------------------------------
// Integer ALU combinational operations
// Add, logic, shift, rotate, byte and bit field operations on one beat.
// ---------------------------------------------------------------------------
module iralu_logic import iralu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic [4:0]  kind,
  input  logic [6:0]  bits,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [7:0]  parity_byte,
  input  logic [5:0]  field_lsb,
  input  logic [6:0]  field_width,
  input  logic        invert_parity,
  input  logic        carry,
  output logic [63:0] result
);

  logic [63:0] m;
  logic [5:0]  amt;
  logic [63:0] fmask;
  logic [63:0] fm;
  logic [63:0] add_x;
  logic [63:0] add_y;
  logic        add_c;
  logic [63:0] sum;
  logic [63:0] swapped;
  logic [63:0] r;

  assign m       = low_mask(bits);
  assign amt     = b[5:0] & 6'(bits - 7'd1);
  assign fmask   = low_mask(field_width);
  assign fm      = fmask << field_lsb;
  assign swapped = {<<8{a}};

  // One shared adder serves add, subtract, carry forms and negate.
  always_comb begin
    add_x = a;
    add_y = b;
    add_c = 1'b0;
    case (kind)
      KIND_SUB: begin
        add_y = ~b;
        add_c = 1'b1;
      end
      KIND_ADC: add_c = carry;
      KIND_SBB: begin
        add_y = ~b;
        add_c = carry;
      end
      KIND_NEG: begin
        add_x = '0;
        add_y = ~a;
        add_c = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = add_x + add_y + {63'd0, add_c};

  // Result selection, masked to the operation width except for sign extend.
  always_comb begin
    r = '0;
    unique case (kind) inside
      KIND_ADD, KIND_SUB, KIND_ADC, KIND_SBB, KIND_NEG: r = sum;
      KIND_AND:     r = a & b;
      KIND_OR:      r = a | b;
      KIND_XOR:     r = a ^ b;
      KIND_ANDNOT:  r = a & ~b;
      KIND_LSL:     r = a << amt;
      KIND_LSR:     r = a >> amt;
      KIND_ASR:     r = 64'($signed(sign_ext(a, bits)) >>> amt);
      KIND_ROR:     r = (amt == 6'd0) ? a : ((a >> amt) | (a << (bits - {1'b0, amt})));
      KIND_BSWAP:   r = (bits <= 7'd8) ? a : (swapped >> (7'd64 - bits));
      KIND_EXTRACT: r = (a >> field_lsb) & fmask;
      KIND_INSERT:  r = (a & ~fm) | ((b << field_lsb) & fm);
      KIND_CLEAR:   r = a & ~fm;
      KIND_SEXT:    r = sign_ext(a, bits) & low_mask(7'(DATA_WIDTH));
      KIND_PARITY:  r = {63'd0, (~^parity_byte) ^ invert_parity};
      KIND_TESTBIT: r = {63'd0, a[field_lsb]};
      default:      r = '0;
    endcase
    if (kind != KIND_SEXT) begin
      r = r & m;
    end
  end

  assign result = r;

endmodule

// File: rtl/iralu_muldiv.sv
// ---------------------------------------------------------------------------
// Integer ALU serial multiply and divide
// Shift-add multiply and restoring divide, one bit per cycle over 64 steps.
// ---------------------------------------------------------------------------
module iralu_muldiv import iralu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  md_req_t     req,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        done,
  output logic [63:0] result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FIX1 = 3'd2;
  localparam logic [2:0] S_FIX2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state;
  logic [5:0]  cnt;
  logic [1:0]  op;
  logic [63:0] upper;
  logic [63:0] lower;
  logic [63:0] opnd;
  logic [63:0] aux;
  logic        neg_x;
  logic        neg_y;
  logic        zero_div;
  logic        neg_q;

  logic [64:0] mul_sum;
  logic [64:0] div_sh;
  logic [64:0] div_diff;
  logic        sx;
  logic        sy;

  assign sx       = req.is_signed & x[63];
  assign sy       = req.is_signed & y[63];
  assign mul_sum  = {1'b0, upper} + {1'b0, (lower[0] ? opnd : 64'd0)};
  assign div_sh   = {upper, lower[63]};
  assign div_diff = div_sh - {1'b0, opnd};

  // Sequencer and shift registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_RUN;
            cnt      <= '0;
            op       <= req.op;
            aux      <= y;
            upper    <= '0;
            neg_x    <= sx;
            neg_y    <= sy;
            zero_div <= (y == 64'd0);
            neg_q    <= sx ^ sy;
            if (req.op == MD_DIV) begin
              lower <= sx ? (64'd0 - x) : x;
              opnd  <= sy ? (64'd0 - y) : y;
            end else begin
              lower <= y;
              opnd  <= x;
            end
          end
        end
        S_RUN: begin
          if (op == MD_DIV) begin
            if (!div_diff[64]) begin
              upper <= div_diff[63:0];
            end else begin
              upper <= div_sh[63:0];
            end
            lower <= {lower[62:0], ~div_diff[64]};
          end else begin
            upper <= mul_sum[64:1];
            lower <= {mul_sum[0], lower[63:1]};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= S_FIX1;
          end
        end
        S_FIX1: begin
          if (op == MD_DIV) begin
            if (zero_div) begin
              lower <= '0;
            end else if (neg_q) begin
              lower <= 64'd0 - lower;
            end
          end else if (neg_x) begin
            upper <= upper - aux;
          end
          state <= S_FIX2;
        end
        S_FIX2: begin
          if (op != MD_DIV && neg_y) begin
            upper <= upper - opnd;
          end
          state <= S_DONE;
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done   = (state == S_DONE);
  assign result = (op == MD_MULH) ? upper : lower;

endmodule

// File: rtl/ir_integer_alu_with_carry_unit.sv
// ---------------------------------------------------------------------------
// Integer ALU with carry
// Runs one integer operation per beat at 8, 16, 32 or 64 bits with a carry.
// ---------------------------------------------------------------------------
// Most operations are registered into the result at the edge that accepts the beat.
// Multiply, high multiply and divide go through a bit-serial shift-add or
// restoring-divide unit that handles one bit per cycle over 64 steps, then
// passes through sign and zero-divide fix-up states and a done state before the result of
// such a beat is registered. One beat is in flight at a time; a new beat is
// taken in the cycle the previous result is taken. The carry flag resets to
// zero and changes only on set-carry and invert-carry.
module ir_integer_alu_with_carry_unit import iralu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  kind,
  input  logic [1:0]  width_code,
  input  logic [63:0] first_operand,
  input  logic [63:0] second_operand,
  input  logic [5:0]  field_lsb,
  input  logic [6:0]  field_width,
  input  logic        is_signed,
  input  logic        invert_parity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_value,
  output logic        carry_now
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic        state;
  logic        carry;
  logic [6:0]  bits;
  logic [63:0] m;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] logic_result;
  logic        accept;
  logic        is_md;
  md_req_t     md_req;
  logic [63:0] md_x;
  logic [63:0] md_y;
  logic        md_done;
  logic [63:0] md_result;
  logic        carry_next;
  logic [63:0] m_hold;

  // Operation width, capped at the data width.
  assign bits = ((7'd8 << width_code) > 7'(DATA_WIDTH)) ? 7'(DATA_WIDTH)
                                                        : (7'd8 << width_code);
  assign m = low_mask(bits);
  assign a = first_operand & m;
  assign b = second_operand & m;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_md    = (kind == KIND_MUL) || (kind == KIND_MULHIGH) || (kind == KIND_DIV);

  // Request for the serial unit.
  always_comb begin
    md_req.is_signed = is_signed;
    md_x = is_signed ? sign_ext(a, bits) : a;
    md_y = is_signed ? sign_ext(b, bits) : b;
    case (kind)
      KIND_MULHIGH: md_req.op = MD_MULH;
      KIND_DIV:     md_req.op = MD_DIV;
      default: begin
        md_req.op        = MD_MUL;
        md_req.is_signed = 1'b0;
        md_x             = a;
        md_y             = b;
      end
    endcase
  end

  iralu_logic #(.DATA_WIDTH(DATA_WIDTH)) u_logic (
    .kind          (kind),
    .bits          (bits),
    .a             (a),
    .b             (b),
    .parity_byte   (first_operand[7:0]),
    .field_lsb     (field_lsb),
    .field_width   (field_width),
    .invert_parity (invert_parity),
    .carry         (carry),
    .result        (logic_result)
  );

  iralu_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && is_md),
    .req    (md_req),
    .x      (md_x),
    .y      (md_y),
    .done   (md_done),
    .result (md_result)
  );

  // Carry update.
  always_comb begin
    carry_next = carry;
    if (accept && kind == KIND_SETCARRY) begin
      carry_next = first_operand[0];
    end else if (accept && kind == KIND_INVCARRY) begin
      carry_next = ~carry;
    end
  end

  // Control and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      carry     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      carry <= carry_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (is_md) begin
          state <= ST_WAIT;
        end else begin
          out_valid    <= 1'b1;
          result_value <= logic_result;
          carry_now    <= carry_next;
        end
      end
      if (state == ST_WAIT && md_done) begin
        state        <= ST_IDLE;
        out_valid    <= 1'b1;
        result_value <= md_result & m_hold;
        carry_now    <= carry;
      end
    end
  end

  // Width mask held for the serial operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_hold <= m;
    end
  end

`include "ir_integer_alu_with_carry_unit_assert.svh"

  `IRALU_ASSERT(a_md_enters_wait, accept && is_md |=> state == ST_WAIT, "serial op did not wait")
  `IRALU_ASSERT(a_done_out_free, md_done |-> !out_valid, "output busy when serial unit done")
  `IRALU_ASSERT(a_setcarry, accept && kind == KIND_SETCARRY |=> carry == $past(first_operand[0]), "set carry failed")
  `IRALU_ASSERT_ALWAYS(a_wait_blocks, state == ST_WAIT |-> !in_ready, "input taken while busy")

endmodule

// File: tb/ir_integer_alu_with_carry_unit_test.sv
// ----------------------------------------------------------------------------
// Integer ALU with carry testbench
// Drives directed and random operations through the valid/ready input,
// predicts each result and the carry flag in a behavioral model, and compares
// every output beat in order under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module ir_integer_alu_with_carry_unit_test import iralu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 64;

  // One input beat.
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  wcode;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [5:0]  flsb;
    logic [6:0]  fwid;
    logic        sgn;
    logic        inv;
  } alu_op_t;

  // One expected result beat.
  typedef struct packed {
    logic [63:0] value;
    logic        carry;
  } alu_res_t;

  // Directed row: operation, whether a literal result is given, and that result.
  typedef struct packed {
    alu_op_t  op;
    logic     fixed;
    alu_res_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  kind = '0;
  logic [1:0]  width_code = '0;
  logic [63:0] first_operand = '0;
  logic [63:0] second_operand = '0;
  logic [5:0]  field_lsb = '0;
  logic [6:0]  field_width = '0;
  logic        is_signed = 1'b0;
  logic        invert_parity = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_value;
  logic        carry_now;

  ir_integer_alu_with_carry_unit #(.DATA_WIDTH(DW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .width_code(width_code),
    .first_operand(first_operand), .second_operand(second_operand),
    .field_lsb(field_lsb), .field_width(field_width),
    .is_signed(is_signed), .invert_parity(invert_parity),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .carry_now(carry_now)
  );

  always #4 clk = ~clk;

  alu_res_t pending_results[$];
  logic     model_carry;
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off_cycles = 0;
  logic     hold_request = 1'b0;
  logic     hold_used = 1'b0;

  function automatic logic [63:0] mask_of(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [63:0] widen_signed(input logic [63:0] v, input int n);
    logic [63:0] m;
    m = mask_of(n);
    v = v & m;
    if (n < 64 && v[n-1]) v = v | ~m;
    return v;
  endfunction

  // Behavioral ALU: computes the result and updates the model carry.
  function automatic alu_res_t alu_predict(input alu_op_t op);
    int          bits;
    int          amt;
    int          fw;
    logic [63:0] m, a, b, r, fm, sa, sb, sw;
    logic [127:0] prod;
    alu_res_t    res;
    bits = 8 << op.wcode;
    if (bits > DW) bits = DW;
    m = mask_of(bits);
    a = op.opa & m;
    b = op.opb & m;
    amt = int'(b & 64'(bits - 1));
    fw = (op.fwid > 7'd64) ? 64 : int'(op.fwid);
    fm = mask_of(fw);
    r = '0;
    case (op.kind)
      KIND_ADD: r = a + b;
      KIND_SUB: r = a - b;
      KIND_ADC: r = a + b + 64'(model_carry);
      KIND_SBB: r = a - b - 64'(!model_carry);
      KIND_MUL: r = a * b;
      KIND_DIV: begin
        if (b == 0) r = '0;
        else if (op.sgn) begin
          sa = widen_signed(a, bits);
          sb = widen_signed(b, bits);
          if (sb == '1) r = -sa;
          else r = 64'($signed(sa) / $signed(sb));
        end else r = a / b;
      end
      KIND_AND: r = a & b;
      KIND_OR: r = a | b;
      KIND_XOR: r = a ^ b;
      KIND_ANDNOT: r = a & ~b;
      KIND_NEG: r = -a;
      KIND_LSL: r = a << amt;
      KIND_LSR: r = a >> amt;
      KIND_ASR: r = 64'($signed(widen_signed(a, bits)) >>> amt);
      KIND_ROR: r = (amt == 0) ? a : ((a >> amt) | (a << (bits - amt)));
      KIND_BSWAP: begin
        sw = {<<8{a}};
        if (bits <= 8) r = a;
        else r = sw >> (64 - bits);
      end
      KIND_EXTRACT: r = (a >> op.flsb) & fm;
      KIND_INSERT: r = (a & ~(fm << op.flsb)) | ((b << op.flsb) & (fm << op.flsb));
      KIND_CLEAR: r = a & ~(fm << op.flsb);
      KIND_MULHIGH: begin
        if (op.sgn) prod = 128'($signed(widen_signed(a, bits))
                                * $signed(widen_signed(b, bits)));
        else prod = {64'd0, a} * {64'd0, b};
        r = prod[127:64];
      end
      KIND_SEXT: r = widen_signed(a, bits) & mask_of(DW);
      KIND_PARITY: r = {63'd0, (~^op.opa[7:0]) ^ op.inv};
      KIND_SETCARRY: model_carry = op.opa[0];
      KIND_INVCARRY: model_carry = ~model_carry;
      KIND_TESTBIT: r = (a >> op.flsb) & 64'd1;
      default: r = '0;
    endcase
    if (op.kind != KIND_SEXT) r = r & m;
    res.value = r;
    res.carry = model_carry;
    return res;
  endfunction

  function automatic alu_op_t mk(input logic [4:0] k, input logic [1:0] w,
                                 input logic [63:0] a, input logic [63:0] b,
                                 input logic [5:0] l, input logic [6:0] f,
                                 input logic s, input logic i);
    alu_op_t op;
    op = '{kind: k, wcode: w, opa: a, opb: b, flsb: l, fwid: f, sgn: s, inv: i};
    return op;
  endfunction

  // Random operation; operands biased toward edge values.
  function automatic alu_op_t random_op();
    alu_op_t op;
    op.kind = ($urandom_range(0, 49) == 0) ? 5'($urandom_range(25, 31))
                                           : 5'($urandom_range(0, 24));
    op.wcode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: op.opa = '1;
      1: op.opa = 64'($urandom_range(0, 3));
      2: op.opa = 64'h8000_0000_0000_0000 >> (64 - (8 << op.wcode));
      default: op.opa = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0: op.opb = '0;
      1: op.opb = '1;
      2: op.opb = 64'($urandom_range(0, 70));
      default: op.opb = {$urandom, $urandom};
    endcase
    op.flsb = 6'($urandom);
    op.fwid = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    op.sgn = 1'($urandom);
    op.inv = 1'($urandom);
    return op;
  endfunction

  // Present one beat and wait for its acceptance; valid drops only when idling.
  task automatic send_op(input alu_op_t op, input logic fixed, input alu_res_t lit);
    alu_res_t exp_res;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    exp_res = alu_predict(op);
    if (fixed) exp_res = lit;
    pending_results.push_back(exp_res);
    in_valid <= 1'b1;
    kind <= op.kind;
    width_code <= op.wcode;
    first_operand <= op.opa;
    second_operand <= op.opb;
    field_lsb <= op.flsb;
    field_width <= op.fwid;
    is_signed <= op.sgn;
    invert_parity <= op.inv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver readiness with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (hold_request && !hold_used) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 400;
      hold_used <= 1'b1;
    end else begin
      out_ready <= !($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected beat value=%h carry=%b", result_value, carry_now);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value || carry_now !== want.carry) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: value exp=%h got=%h carry exp=%b got=%b",
                     want.value, result_value, want.carry, carry_now);
        end
      end
    end
  end

  row_t directed[] = '{
    // Carry reads zero after reset.
    '{mk(KIND_ADC, 2'd3, '1, 64'd0, 0, 0, 0, 0), 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
    '{mk(KIND_ADD, 2'd0, 64'h1FF, 64'h01, 0, 0, 0, 0), 1'b1, '{64'h0, 1'b0}},
    '{mk(KIND_SUB, 2'd1, 64'd0, 64'd1, 0, 0, 0, 0), 1'b1, '{64'hFFFF, 1'b0}},
    '{mk(KIND_SBB, 2'd2, 64'd5, 64'd1, 0, 0, 0, 0), 1'b1, '{64'd3, 1'b0}},
    '{mk(KIND_SETCARRY, 2'd3, 64'd1, 64'd0, 0, 0, 0, 0), 1'b1, '{64'd0, 1'b1}},
    '{mk(KIND_ADC, 2'd3, '1, 64'd0, 0, 0, 0, 0), 1'b1, '{64'd0, 1'b1}},
    '{mk(KIND_SBB, 2'd0, 64'd5, 64'd1, 0, 0, 0, 0), 1'b1, '{64'd4, 1'b1}},
    '{mk(KIND_INVCARRY, 2'd0, '0, '0, 0, 0, 0, 0), 1'b1, '{64'd0, 1'b0}},
    '{mk(KIND_MUL, 2'd3, '1, '1, 0, 0, 0, 0), 1'b1, '{64'd1, 1'b0}},
    // Division by zero, and signed division by minus one wrapping.
    '{mk(KIND_DIV, 2'd3, 64'd77, 64'd0, 0, 0, 1, 0), 1'b1, '{64'd0, 1'b0}},
    '{mk(KIND_DIV, 2'd0, 64'h80, 64'hFF, 0, 0, 1, 0), 1'b1, '{64'h80, 1'b0}},
    '{mk(KIND_DIV, 2'd3, '1, 64'd7, 0, 0, 0, 0), 1'b0, '0},
    '{mk(KIND_DIV, 2'd2, 64'hFFFF_FFF0, 64'd3, 0, 0, 1, 0), 1'b0, '0},
    '{mk(KIND_AND, 2'd3, '1, 64'hA5A5, 0, 0, 0, 0), 1'b0, '0},
    '{mk(KIND_OR, 2'd1, 64'hF0F0, 64'h0F0F, 0, 0, 0, 0), 1'b0, '0},
    '{mk(KIND_XOR, 2'd2, '1, 64'h1234, 0, 0, 0, 0), 1'b0, '0},
    '{mk(KIND_ANDNOT, 2'd3, '1, 64'hFF, 0, 0, 0, 0), 1'b0, '0},
    '{mk(KIND_NEG, 2'd0, 64'd1, 0, 0, 0, 0, 0), 1'b1, '{64'hFF, 1'b0}},
    '{mk(KIND_ASR, 2'd1, 64'h8000, 64'd19, 0, 0, 0, 0), 1'b1, '{64'hF000, 1'b0}},
    '{mk(KIND_ROR, 2'd0, 64'h01, 64'd1, 0, 0, 0, 0), 1'b1, '{64'h80, 1'b0}},
    '{mk(KIND_BSWAP, 2'd0, 64'h1234, 0, 0, 0, 0, 0), 1'b1, '{64'h34, 1'b0}},
    // Field width zero and over 64.
    '{mk(KIND_EXTRACT, 2'd3, '1, 0, 6'd4, 7'd0, 0, 0), 1'b1, '{64'd0, 1'b0}},
    '{mk(KIND_INSERT, 2'd3, '0, '1, 6'd0, 7'd127, 0, 0), 1'b1, '{'1, 1'b0}},
    '{mk(KIND_CLEAR, 2'd3, '1, 0, 6'd63, 7'd64, 0, 0), 1'b0, '0},
    '{mk(KIND_MULHIGH, 2'd3, '1, '1, 0, 0, 1, 0), 1'b1, '{64'd0, 1'b0}},
    '{mk(KIND_SEXT, 2'd0, 64'h80, 0, 0, 0, 0, 0), 1'b1, '{64'hFFFF_FFFF_FFFF_FF80, 1'b0}},
    '{mk(KIND_PARITY, 2'd0, 64'h03, 0, 0, 0, 0, 1), 1'b1, '{64'd0, 1'b0}},
    '{mk(KIND_TESTBIT, 2'd3, 64'h8000_0000_0000_0000, 0, 6'd63, 0, 0, 0), 1'b1, '{64'd1, 1'b0}},
    '{mk(5'd31, 2'd3, '1, '1, 0, 0, 0, 0), 1'b1, '{64'd0, 1'b0}}
  };

  // Main sequence: reset, directed table, then random phases.
  initial begin
    model_carry = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_op(directed[i].op, directed[i].fixed, directed[i].res);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        3: begin send_idle_pct = 32; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 4 && n == 10) hold_request <= 1'b1;
        if (ph == 4 && n == 11) hold_request <= 1'b0;
        send_op(random_op(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    hold_request <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
